FILE: hw/rtl/bpr_pkg.sv
// shared types and constants of the buck pi pwm regulator
package bpr_pkg;

   localparam int SETPOINT_W = 20;
   localparam int GAIN_W     = 32;
   localparam int SAMPLE_W   = 12;
   localparam int COMPARE_W  = 11;
   localparam int ERR_W      = 22;
   localparam int SUM_W      = 23;
   localparam int PROP_W     = 55;
   localparam int INC_W      = 56;
   localparam int FRAC_W     = 40;
   localparam int PERIOD_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // register index codes
   localparam logic [CSR_IDX_W-1:0] CSR_SETPOINT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIP_LEVEL = 2'd3;

   // request opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_EDGE   = 1'b1;

   // reset values of the registers
   localparam logic [SETPOINT_W-1:0] SETPOINT_RST   = 20'd1027604;
   localparam logic [GAIN_W-1:0]     PROP_GAIN_RST  = 32'd429497;
   localparam logic [GAIN_W-1:0]     INTEG_GAIN_RST = 32'd236223;
   localparam logic [SAMPLE_W-1:0]   TRIP_LEVEL_RST = 12'd4095;

   typedef logic signed [63:0]      acc_type;
   typedef logic signed [64:0]      acc_wide_type;
   typedef logic [PERIOD_W:0]       span_type;

   localparam acc_type ACC_MAX = {1'b0, {63{1'b1}}};
   localparam acc_type ACC_MIN = {1'b1, {63{1'b0}}};

   typedef struct packed {
      logic updated;
      logic running;
      logic tripped;
   } flags_type;

endpackage

FILE: hw/rtl/buck_pi_pwm_regulator.sv
// buck regulator pi step: error, pi terms, trapezoidal integrator, pwm compare
//
// usage
//   request channel (req_*): one request per item. opcode edge toggles the run
//   state; opcode sample carries a 12-bit adc result, which while running is
//   trip-checked and drives the pi controller. samples while stopped are
//   ignored but still answered.
//   response channel (rsp_*): exactly one response per request, in order.
//   compare is the new pwm compare value when updated is set, else the last one.
//   running and tripped show the state after that request.
//   csr_* : plain write port; the user must write it only while the block is idle, the block does not enforce this.
// throughput and pipeline
//   one request per cycle sustained while the response side does not stall; a
//   request passes the error stage, multiplier stage, integrator stage and output
//   register in that order. the integrator's saturating 64-bit add is combinational.
// reset
//   synchronous, active high: registers to their defaults, stopped, integrator,
//   previous error, trip latch and compare cleared, pipeline emptied.
// stall
//   a stalled response holds; the pipeline fills its empty stages first and
//   stalls the request side only once every stage holds a request
module buck_pi_pwm_regulator #(
   parameter int PWM_PERIOD = 1500
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_opcode,
   input  logic [bpr_pkg::SAMPLE_W-1:0]      req_sample,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bpr_pkg::COMPARE_W-1:0]     rsp_compare,
   output logic                              rsp_running,
   output logic                              rsp_tripped,
   output logic                              rsp_updated,
   // register write port
   input  logic                              csr_we,
   input  logic [bpr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bpr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // clamp limit of the integrator copy and the total, in q.40
   localparam bpr_pkg::acc_type Limit = bpr_pkg::acc_type'(PWM_PERIOD) <<< bpr_pkg::FRAC_W;
   localparam bpr_pkg::span_type PeriodSpan = bpr_pkg::span_type'(PWM_PERIOD);

   // configuration registers
   logic [bpr_pkg::SETPOINT_W-1:0] setpoint_ff;
   logic [bpr_pkg::GAIN_W-1:0]     prop_gain_ff;
   logic [bpr_pkg::GAIN_W-1:0]     integ_gain_ff;
   logic [bpr_pkg::SAMPLE_W-1:0]   trip_level_ff;

   // controller state
   logic                           run_ff;
   logic                           trip_ff;
   logic signed [bpr_pkg::ERR_W-1:0] prev_err_ff;
   bpr_pkg::acc_type               acc_ff;

   // pipeline registers
   logic                           s1_valid_ff;
   bpr_pkg::flags_type             s1_flags_ff;
   logic signed [bpr_pkg::ERR_W-1:0] s1_err_ff;
   logic signed [bpr_pkg::SUM_W-1:0] s1_sum_ff;

   logic                           s2_valid_ff;
   bpr_pkg::flags_type             s2_flags_ff;
   logic signed [bpr_pkg::PROP_W-1:0] s2_prop_ff;
   logic signed [bpr_pkg::INC_W-1:0]  s2_inc_ff;

   logic                           s3_valid_ff;
   bpr_pkg::flags_type             s3_flags_ff;
   logic signed [bpr_pkg::PROP_W-1:0] s3_prop_ff;
   bpr_pkg::acc_type               s3_integ_ff;

   logic                           rsp_valid_ff;
   bpr_pkg::flags_type             rsp_flags_ff;
   logic [bpr_pkg::COMPARE_W-1:0]  rsp_compare_ff;   // doubles as last compare

   // flow control: each stage loads when it is empty or drains this cycle
   logic out_free, s3_free, s2_free, s1_free, req_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s3_free   = !s3_valid_ff || out_free;
   assign s2_free   = !s2_valid_ff || s3_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = !s1_free;
   assign req_take  = req_valid && !req_stall;

   // request stage: run toggle, trip check, q.8 error and trapezoid sum
   logic                              is_edge;
   logic                              do_upd;
   logic                              run_in;
   logic                              trip_in;
   logic signed [bpr_pkg::ERR_W-1:0]  err_in;
   logic signed [bpr_pkg::SUM_W-1:0]  sum_in;
   bpr_pkg::flags_type                s1_flags_in;

   always_comb begin
      is_edge = (req_opcode == bpr_pkg::OP_EDGE);
      do_upd  = !is_edge && run_ff;
      run_in  = run_ff ^ is_edge;
      trip_in = trip_ff || (do_upd && (req_sample > trip_level_ff));
      err_in  = $signed({2'b00, setpoint_ff}) - $signed({2'b00, req_sample, 8'h00});
      sum_in  = bpr_pkg::SUM_W'(err_in) + bpr_pkg::SUM_W'(prev_err_ff);
      s1_flags_in = '{updated: do_upd, running: run_in, tripped: trip_in};
   end

   // multiplier stage: proportional term and integrator increment
   logic signed [bpr_pkg::PROP_W-1:0] s2_prop_in;
   logic signed [bpr_pkg::INC_W-1:0]  s2_inc_in;

   assign s2_prop_in = s1_err_ff * $signed({1'b0, prop_gain_ff});
   assign s2_inc_in  = s1_sum_ff * $signed({1'b0, integ_gain_ff});

   // integrator stage: saturating 64-bit add, clamped copy for the output
   bpr_pkg::acc_wide_type acc_sum;
   bpr_pkg::acc_type      acc_in;
   bpr_pkg::acc_type      s3_integ_in;

   always_comb begin
      acc_sum = bpr_pkg::acc_wide_type'(acc_ff) + bpr_pkg::acc_wide_type'(s2_inc_ff);
      if (acc_sum[64] != acc_sum[63]) begin
         acc_in = acc_sum[64] ? bpr_pkg::ACC_MIN : bpr_pkg::ACC_MAX;
      end else begin
         acc_in = acc_sum[63:0];
      end
      priority if (acc_in >= Limit) begin
         s3_integ_in = Limit;
      end else if (acc_in <= -Limit) begin
         s3_integ_in = -Limit;
      end else begin
         s3_integ_in = acc_in;
      end
   end

   // output stage: total, clamp to 0..period, floor, compare = period - whole
   bpr_pkg::acc_type                 total;
   bpr_pkg::acc_type                 total_cl;
   logic [bpr_pkg::PERIOD_W-1:0]     whole;
   bpr_pkg::span_type                span;
   logic [bpr_pkg::COMPARE_W-1:0]    compare_in;

   always_comb begin
      total = s3_integ_ff + bpr_pkg::acc_type'(s3_prop_ff);
      priority if (total >= Limit) begin
         total_cl = Limit;
      end else if (total <= 0) begin
         total_cl = '0;
      end else begin
         total_cl = total;
      end
      whole      = total_cl[bpr_pkg::FRAC_W +: bpr_pkg::PERIOD_W];
      span       = PeriodSpan - {1'b0, whole};
      compare_in = s3_flags_ff.updated ? span[bpr_pkg::COMPARE_W-1:0] : rsp_compare_ff;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff   <= bpr_pkg::SETPOINT_RST;
         prop_gain_ff  <= bpr_pkg::PROP_GAIN_RST;
         integ_gain_ff <= bpr_pkg::INTEG_GAIN_RST;
         trip_level_ff <= bpr_pkg::TRIP_LEVEL_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            bpr_pkg::CSR_SETPOINT:   setpoint_ff   <= csr_wdata[bpr_pkg::SETPOINT_W-1:0];
            bpr_pkg::CSR_PROP_GAIN:  prop_gain_ff  <= csr_wdata[bpr_pkg::GAIN_W-1:0];
            bpr_pkg::CSR_INTEG_GAIN: integ_gain_ff <= csr_wdata[bpr_pkg::GAIN_W-1:0];
            bpr_pkg::CSR_TRIP_LEVEL: trip_level_ff <= csr_wdata[bpr_pkg::SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   // controller state and pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff         <= 1'b0;
         trip_ff        <= 1'b0;
         prev_err_ff    <= '0;
         acc_ff         <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rsp_compare_ff <= '0;
      end else begin
         if (req_take) begin
            run_ff  <= run_in;
            trip_ff <= trip_in;
            if (do_upd) begin
               prev_err_ff <= err_in;
            end
         end
         if (s1_free) begin
            s1_valid_ff <= req_take;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_free) begin
            s3_valid_ff <= s2_valid_ff;
            if (s2_valid_ff && s2_flags_ff.updated) begin
               acc_ff <= acc_in;
            end
         end
         if (out_free) begin
            rsp_valid_ff <= s3_valid_ff;
            if (s3_valid_ff) begin
               rsp_compare_ff <= compare_in;
            end
         end
      end
   end

   // pipeline payload, no reset needed
   always_ff @(posedge clock) begin
      if (s1_free && req_take) begin
         s1_flags_ff <= s1_flags_in;
         s1_err_ff   <= err_in;
         s1_sum_ff   <= sum_in;
      end
      if (s2_free && s1_valid_ff) begin
         s2_flags_ff <= s1_flags_ff;
         s2_prop_ff  <= s2_prop_in;
         s2_inc_ff   <= s2_inc_in;
      end
      if (s3_free && s2_valid_ff) begin
         s3_flags_ff <= s2_flags_ff;
         s3_prop_ff  <= s2_prop_ff;
         s3_integ_ff <= s3_integ_in;
      end
      if (out_free && s3_valid_ff) begin
         rsp_flags_ff <= s3_flags_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_compare = rsp_compare_ff;
   assign rsp_running = rsp_flags_ff.running;
   assign rsp_tripped = rsp_flags_ff.tripped;
   assign rsp_updated = rsp_flags_ff.updated;

endmodule

FILE: hw/rtl/bpr_checker.sv
// port-level checker of the buck pi pwm regulator and its bind
module bpr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           req_opcode,
   input logic [bpr_pkg::SAMPLE_W-1:0]   req_sample,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [bpr_pkg::COMPARE_W-1:0]  rsp_compare,
   input logic                           rsp_running,
   input logic                           rsp_tripped,
   input logic                           rsp_updated,
   input logic                           csr_we,
   input logic [bpr_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [bpr_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_compare)
         && $stable(rsp_updated) && $stable(rsp_tripped))
      else $error("stalled response changed");

   // trip latch never clears short of reset
   a_trip_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tripped |=> !rsp_valid || rsp_tripped)
      else $error("trip latch released");

   // a new compare only comes from a running regulator
   a_upd_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_updated |-> rsp_running)
      else $error("compare updated while stopped");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind buck_pi_pwm_regulator bpr_checker u_bpr_checker (.*);
